// File: hw/rtl/rpbb_pkg.sv
// Shared types, constants and codes of the rational point bounding box unit.
`timescale 1ns / 1ps
package rpbb_pkg;

	localparam int AXES_DEF = 3;
	localparam int MAX_AXES = 3;
	localparam int CW       = 32;
	localparam int VW       = 48;
	localparam int FRAC     = 16;
	localparam int LBW      = 47;
	localparam int CNT_W    = $clog2(VW);

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VW - 1);

	localparam logic signed [VW-1:0] POS_INF = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] NEG_INF = {1'b1, {(VW-1){1'b0}}};
	localparam logic [LBW-1:0] LB_RESET = LBW'(64'd68719476736);

	typedef enum logic [1:0] {
		CFG_RATIONAL = 2'd0,
		CFG_IGNORE   = 2'd1,
		CFG_MASK     = 2'd2,
		CFG_LARGE    = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic signed [CW-1:0] weight;
		logic signed [CW-1:0] coord_x;
		logic signed [CW-1:0] coord_y;
		logic signed [CW-1:0] coord_z;
		logic                 last_point;
	} point_t;

	typedef struct packed {
		logic signed [VW-1:0] min_x;
		logic signed [VW-1:0] max_x;
		logic signed [VW-1:0] min_y;
		logic signed [VW-1:0] max_y;
		logic signed [VW-1:0] min_z;
		logic signed [VW-1:0] max_z;
		logic                 mixed_weights;
	} box_t;

	typedef struct packed {
		logic signed [VW-1:0] p_min;
		logic signed [VW-1:0] p_max;
		logic signed [VW-1:0] m_min;
		logic signed [VW-1:0] m_max;
	} bnd_t;

	typedef enum logic [2:0] {
		UPD_SKIP       = 3'd0,
		UPD_WIDEN_BOTH = 3'd1,
		UPD_PLAIN_ONLY = 3'd2,
		UPD_NEG_FORCE  = 3'd3,
		UPD_MAX_INF    = 3'd4,
		UPD_MIN_INF    = 3'd5
	} upd_op_t;

	typedef struct packed {
		upd_op_t              op;
		logic signed [VW-1:0] val;
		logic [LBW-1:0]       bound;
	} upd_t;

	typedef struct packed {
		logic [VW-1:0] num;
		logic [CW-1:0] den;
		logic          neg;
	} div_req_t;

endpackage

// File: hw/rtl/rational_point_bounding_box_unit.sv
// Top level of the rational point bounding box unit: sequencer, registers and handshakes.
`timescale 1ns / 1ps
// A point is taken when point_valid is high and point_stall low; point_stall stays high while
// the point is worked on. In rational mode each axis with a nonzero weight goes through one
// shared 48-step radix-2 divider; a zero weight or raw mode bypasses the divider. The point
// marked last_point then loads the box, which is held in an output register
// until taken, so the next set may start meanwhile; a second last point waits only while that
// register is still full and box_stall is high.
// Configuration writes are taken at any time but must only be made while the unit is idle.
module rational_point_bounding_box_unit #(
	parameter int AXES = rpbb_pkg::AXES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      point_valid,
	output logic                      point_stall,
	input  rpbb_pkg::point_t          point,
	output logic                      box_valid,
	input  logic                      box_stall,
	output rpbb_pkg::box_t            box,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [rpbb_pkg::LBW-1:0]  cfg_data
);
	import rpbb_pkg::*;

	localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_AXIS = 4'b0010,
		S_DIV  = 4'b0100,
		S_DONE = 4'b1000
	} st_t;

	st_t state_q;
	st_t state_nxt;

	logic           rational_q;
	logic           ignore_q;
	logic [2:0]     mask_q;
	logic [LBW-1:0] large_q;

	logic seen_pos_q;
	logic seen_neg_q;
	logic last_q;
	logic signed [CW-1:0] weight_q;
	logic signed [CW-1:0] coord_q [AXES];
	logic [AW-1:0] ax_q;
	logic          box_valid_q;
	box_t          box_q;

	logic signed [CW-1:0] coord_in [MAX_AXES];
	logic take;
	logic ax_last;
	logic out_free;
	logic step;
	logic clear;
	upd_t upd;
	logic div_start;
	div_req_t div_req;
	logic div_done;
	logic signed [VW-1:0] div_quo;
	logic [CW-1:0] c_abs;
	logic [CW-1:0] w_abs;
	logic signed [CW-1:0] c_head;
	logic mixed;
	bnd_t [AXES-1:0] bounds;
	logic signed [VW-1:0] lo_v [MAX_AXES];
	logic signed [VW-1:0] hi_v [MAX_AXES];

	assign take      = point_valid && !point_stall;
	assign point_stall = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign ax_last   = (ax_q == AW'(AXES - 1));
	assign out_free  = !box_valid_q || !box_stall;
	assign mixed     = rational_q && seen_pos_q && seen_neg_q;
	assign coord_in[0] = point.coord_x;
	assign coord_in[1] = point.coord_y;
	assign coord_in[2] = point.coord_z;
	assign c_head    = coord_q[0];
	assign c_abs     = c_head[CW-1] ? (CW'(0) - c_head) : c_head;
	assign w_abs     = weight_q[CW-1] ? (CW'(0) - weight_q) : weight_q;

	always_comb begin
		div_req.num = {c_abs, {FRAC{1'b0}}};
		div_req.den = w_abs;
		div_req.neg = c_head[CW-1] ^ weight_q[CW-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rational_q <= 1'b0;
			ignore_q   <= 1'b0;
			mask_q     <= 3'b111;
			large_q    <= LB_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_RATIONAL: rational_q <= cfg_data[0];
				CFG_IGNORE:   ignore_q   <= cfg_data[0];
				CFG_MASK:     mask_q     <= cfg_data[2:0];
				CFG_LARGE:    large_q    <= cfg_data;
				default:      rational_q <= rational_q;
			endcase
		end
	end

	always_comb begin
		state_nxt = state_q;
		step      = 1'b0;
		clear     = 1'b0;
		div_start = 1'b0;
		upd.op    = UPD_SKIP;
		upd.val   = {{(VW-CW){c_head[CW-1]}}, c_head};
		upd.bound = large_q;
		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					state_nxt = S_AXIS;
				end
			end
			S_AXIS: begin
				if (!rational_q) begin
					step   = 1'b1;
					upd.op = UPD_WIDEN_BOTH;
				end else if (weight_q == '0) begin
					step = 1'b1;
					if (c_head == '0 || ignore_q) begin
						upd.op = UPD_SKIP;
					end else if (c_head[CW-1]) begin
						upd.op = UPD_MIN_INF;
					end else begin
						upd.op = UPD_MAX_INF;
					end
				end else begin
					div_start = 1'b1;
					state_nxt = S_DIV;
				end
				if (step) begin
					state_nxt = ax_last ? (last_q ? S_DONE : S_IDLE) : S_AXIS;
				end
			end
			S_DIV: begin
				upd.val = div_quo;
				if (div_done) begin
					step = 1'b1;
					if (!weight_q[CW-1]) begin
						upd.op = UPD_WIDEN_BOTH;
					end else if (ignore_q) begin
						upd.op = UPD_PLAIN_ONLY;
					end else begin
						upd.op = UPD_NEG_FORCE;
					end
					state_nxt = ax_last ? (last_q ? S_DONE : S_IDLE) : S_AXIS;
				end
			end
			S_DONE: begin
				if (out_free) begin
					clear     = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ax_q        <= '0;
			seen_pos_q  <= 1'b0;
			seen_neg_q  <= 1'b0;
			box_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (take) begin
				ax_q <= '0;
				if (rational_q) begin
					seen_pos_q <= seen_pos_q | (!point.weight[CW-1] && point.weight != '0);
					seen_neg_q <= seen_neg_q | point.weight[CW-1];
				end
			end else if (step) begin
				ax_q <= ax_last ? '0 : ax_q + 1'b1;
			end
			if (clear) begin
				seen_pos_q  <= 1'b0;
				seen_neg_q  <= 1'b0;
				box_valid_q <= 1'b1;
			end else if (box_valid_q && !box_stall) begin
				box_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			weight_q <= point.weight;
			last_q   <= point.last_point;
			for (int i = 0; i < AXES; i++) begin
				coord_q[i] <= coord_in[i];
			end
		end else if (step) begin
			for (int i = 0; i < AXES - 1; i++) begin
				coord_q[i] <= coord_q[i+1];
			end
			coord_q[AXES-1] <= coord_q[0];
		end
		if (clear) begin
			box_q.min_x         <= lo_v[0];
			box_q.max_x         <= hi_v[0];
			box_q.min_y         <= lo_v[1];
			box_q.max_y         <= hi_v[1];
			box_q.min_z         <= lo_v[2];
			box_q.max_z         <= hi_v[2];
			box_q.mixed_weights <= mixed;
		end
	end

	for (genvar a = 0; a < MAX_AXES; a++) begin : g_axis
		if (a < AXES) begin : g_on
			assign lo_v[a] = mask_q[a] ? (mixed ? bounds[a].m_min : bounds[a].p_min) : '0;
			assign hi_v[a] = mask_q[a] ? (mixed ? bounds[a].m_max : bounds[a].p_max) : '0;
		end else begin : g_off
			assign lo_v[a] = '0;
			assign hi_v[a] = '0;
		end
	end

	assign box_valid = box_valid_q;
	assign box       = box_q;

	rpbb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.req    (div_req),
		.done   (div_done),
		.quo    (div_quo)
	);

	rpbb_track #(
		.AXES (AXES)
	) u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (clear),
		.step   (step),
		.upd    (upd),
		.bounds (bounds)
	);

`ifndef SYNTH
	a_div_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("quotient arrived outside the divide wait");
	a_box_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(box_valid_q) |-> $past(state_q == S_DONE))
		else $error("box loaded outside the done state");
	a_take_starts: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> state_q == S_AXIS && ax_q == '0)
		else $error("accepted point did not start at the first axis");
`endif

endmodule

// File: hw/rtl/rpbb_div.sv
// Shared radix-2 restoring divider: signed Q32.16 quotient, saturated to 48 bits.
`timescale 1ns / 1ps
module rpbb_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  rpbb_pkg::div_req_t          req,
	output logic                        done,
	output logic signed [rpbb_pkg::VW-1:0] quo
);
	import rpbb_pkg::*;

	logic             busy_q;
	logic             fix_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [VW-1:0]    num_q;
	logic [CW-1:0]    den_q;
	logic [CW-1:0]    rem_q;
	logic [VW-1:0]    quo_q;
	logic             neg_q;
	logic signed [VW-1:0] res_q;

	logic [CW+1:0] trial;
	logic          qbit;
	logic [CW-1:0] rem_nxt;
	logic [VW-1:0] quo_neg;
	logic signed [VW-1:0] fixed;

	always_comb begin
		trial   = {1'b0, rem_q, num_q[VW-1]} - {2'b00, den_q};
		qbit    = ~trial[CW+1];
		rem_nxt = qbit ? trial[CW-1:0] : {rem_q[CW-2:0], num_q[VW-1]};
		quo_neg = '0 - quo_q;
		if (neg_q) begin
			fixed = quo_neg;
		end else if (quo_q[VW-1]) begin
			fixed = POS_INF;
		end else begin
			fixed = quo_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fix_q;
			fix_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					fix_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= req.num;
			den_q <= req.den;
			neg_q <= req.neg;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			num_q <= {num_q[VW-2:0], 1'b0};
			quo_q <= {quo_q[VW-2:0], qbit};
		end
		if (fix_q) begin
			res_q <= fixed;
		end
	end

	assign done = done_q;
	assign quo  = res_q;

`ifndef SYNTH
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q && !fix_q)
		else $error("divider started while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held longer than one cycle");
	a_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !start && cnt_q == CNT_LAST) |=> fix_q && !busy_q)
		else $error("divider did not finish after its last step");
`endif

endmodule

// File: hw/rtl/rpbb_track.sv
// Plain and mixed bound tracks, one axis updated per step, rotated through the head slot.
`timescale 1ns / 1ps
module rpbb_track #(
	parameter int AXES = rpbb_pkg::AXES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clear,
	input  logic                          step,
	input  rpbb_pkg::upd_t                upd,
	output rpbb_pkg::bnd_t [AXES-1:0]     bounds
);
	import rpbb_pkg::*;

	bnd_t [AXES-1:0] bnd_q;
	bnd_t            head_nxt;
	logic signed [VW-1:0] lb_pos;
	logic signed [VW-1:0] lb_neg;

	function automatic logic signed [VW-1:0] lower(input logic signed [VW-1:0] a,
		input logic signed [VW-1:0] b);
		return (a > b) ? b : a;
	endfunction

	function automatic logic signed [VW-1:0] upper(input logic signed [VW-1:0] a,
		input logic signed [VW-1:0] b);
		return (a < b) ? b : a;
	endfunction

	always_comb begin
		lb_pos   = {1'b0, upd.bound};
		lb_neg   = '0 - lb_pos;
		head_nxt = bnd_q[0];
		unique case (upd.op)
			UPD_WIDEN_BOTH: begin
				head_nxt.p_min = lower(bnd_q[0].p_min, upd.val);
				head_nxt.p_max = upper(bnd_q[0].p_max, upd.val);
				head_nxt.m_min = lower(bnd_q[0].m_min, upd.val);
				head_nxt.m_max = upper(bnd_q[0].m_max, upd.val);
			end
			UPD_PLAIN_ONLY: begin
				head_nxt.p_min = lower(bnd_q[0].p_min, upd.val);
				head_nxt.p_max = upper(bnd_q[0].p_max, upd.val);
			end
			UPD_NEG_FORCE: begin
				head_nxt.p_min = lower(bnd_q[0].p_min, upd.val);
				head_nxt.p_max = upper(bnd_q[0].p_max, upd.val);
				head_nxt.m_min = lb_neg;
				head_nxt.m_max = lb_pos;
			end
			UPD_MAX_INF: begin
				head_nxt.p_max = POS_INF;
				head_nxt.m_max = POS_INF;
			end
			UPD_MIN_INF: begin
				head_nxt.p_min = NEG_INF;
				head_nxt.m_min = NEG_INF;
			end
			default: begin
				head_nxt = bnd_q[0];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++) begin
				bnd_q[i] <= '{p_min: POS_INF, p_max: NEG_INF, m_min: POS_INF, m_max: NEG_INF};
			end
		end else if (clear) begin
			for (int i = 0; i < AXES; i++) begin
				bnd_q[i] <= '{p_min: POS_INF, p_max: NEG_INF, m_min: POS_INF, m_max: NEG_INF};
			end
		end else if (step) begin
			for (int i = 0; i < AXES - 1; i++) begin
				bnd_q[i] <= bnd_q[i+1];
			end
			bnd_q[AXES-1] <= head_nxt;
		end
	end

	assign bounds = bnd_q;

endmodule

// File: tb/sv/tb_top.sv
// Self-checking bench for the rational point bounding box unit: directed table, then random sets.
`timescale 1ns / 1ps
module tb_top;
	import rpbb_pkg::*;

	localparam int CYCLE_LIMIT  = 1_500_000;
	localparam int SETTLE       = 250;
	localparam int PHASES       = 8;
	localparam int PHASE_POINTS = 119;

	typedef enum bit {ROW_POINT, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t      kind;
		cfg_idx_t       idx;
		logic [LBW-1:0] data;
		point_t         pt;
		bit             typed;
		box_t           want;
	} row_t;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           point_valid = 1'b0;
	logic           point_stall;
	point_t         point = '0;
	logic           box_valid;
	logic           box_stall = 1'b0;
	box_t           box;
	logic           cfg_valid = 1'b0;
	logic           cfg_ready;
	logic [1:0]     cfg_index = CFG_RATIONAL;
	logic [LBW-1:0] cfg_data = '0;

	bit             cf_rational = 1'b0;
	bit             cf_ignore = 1'b0;
	logic [2:0]     cf_mask = 3'd7;
	logic [LBW-1:0] cf_large = LB_RESET;

	logic signed [VW-1:0] pl_lo[3];
	logic signed [VW-1:0] pl_hi[3];
	logic signed [VW-1:0] mx_lo[3];
	logic signed [VW-1:0] mx_hi[3];
	bit seen_pos;
	bit seen_neg;

	box_t boxes_due[$];
	int   send_pct = 0;
	int   stall_pct = 0;
	int   err_count = 0;
	int   points_sent = 0;
	int   boxes_checked = 0;
	int   reg_writes = 0;
	int   cycle_count = 0;

	rational_point_bounding_box_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.point_valid(point_valid),
		.point_stall(point_stall),
		.point      (point),
		.box_valid  (box_valid),
		.box_stall  (box_stall),
		.box        (box),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic void clear_tracks();
		for (int a = 0; a < 3; a++) begin
			pl_lo[a] = POS_INF;
			pl_hi[a] = NEG_INF;
			mx_lo[a] = POS_INF;
			mx_hi[a] = NEG_INF;
		end
		seen_pos = 1'b0;
		seen_neg = 1'b0;
	endfunction

	function automatic void fold_point(input point_t p, output bit done, output box_t b);
		longint w;
		longint c;
		longint q;
		logic signed [VW-1:0] v;
		logic signed [CW-1:0] crd[3];
		logic signed [VW-1:0] lo[3];
		logic signed [VW-1:0] hi[3];
		bit mixed;
		w = longint'($signed(p.weight));
		crd[0] = p.coord_x;
		crd[1] = p.coord_y;
		crd[2] = p.coord_z;
		if (cf_rational) begin
			if (w > 0)
				seen_pos = 1'b1;
			if (w < 0)
				seen_neg = 1'b1;
		end
		for (int a = 0; a < AXES_DEF; a++) begin
			c = longint'($signed(crd[a]));
			if (!cf_rational) begin
				v = VW'(c);
				if (pl_lo[a] > v) pl_lo[a] = v;
				if (pl_hi[a] < v) pl_hi[a] = v;
				if (mx_lo[a] > v) mx_lo[a] = v;
				if (mx_hi[a] < v) mx_hi[a] = v;
			end else if (w == 0) begin
				if (c != 0 && !cf_ignore) begin
					if (c > 0) begin
						pl_hi[a] = POS_INF;
						mx_hi[a] = POS_INF;
					end else begin
						pl_lo[a] = NEG_INF;
						mx_lo[a] = NEG_INF;
					end
				end
			end else begin
				q = (c * 65536) / w;
				if (q > longint'(POS_INF))
					q = longint'(POS_INF);
				if (q < longint'(NEG_INF))
					q = longint'(NEG_INF);
				v = VW'(q);
				if (pl_lo[a] > v) pl_lo[a] = v;
				if (pl_hi[a] < v) pl_hi[a] = v;
				if (w > 0) begin
					if (mx_lo[a] > v) mx_lo[a] = v;
					if (mx_hi[a] < v) mx_hi[a] = v;
				end else if (!cf_ignore) begin
					mx_hi[a] = {1'b0, cf_large};
					mx_lo[a] = -$signed({1'b0, cf_large});
				end
			end
		end
		done = p.last_point;
		b = '0;
		if (!done)
			return;
		mixed = cf_rational && seen_pos && seen_neg;
		for (int a = 0; a < 3; a++) begin
			lo[a] = '0;
			hi[a] = '0;
			if (a < AXES_DEF && cf_mask[a]) begin
				lo[a] = mixed ? mx_lo[a] : pl_lo[a];
				hi[a] = mixed ? mx_hi[a] : pl_hi[a];
			end
		end
		b.min_x = lo[0];
		b.max_x = hi[0];
		b.min_y = lo[1];
		b.max_y = hi[1];
		b.min_z = lo[2];
		b.max_z = hi[2];
		b.mixed_weights = mixed;
		clear_tracks();
	endfunction

	function automatic row_t mk_pt(logic signed [CW-1:0] w, logic signed [CW-1:0] x,
			logic signed [CW-1:0] y, logic signed [CW-1:0] z, bit last);
		row_t r;
		r.kind = ROW_POINT;
		r.idx = CFG_RATIONAL;
		r.data = '0;
		r.pt.weight = w;
		r.pt.coord_x = x;
		r.pt.coord_y = y;
		r.pt.coord_z = z;
		r.pt.last_point = last;
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic row_t mk_cfg(cfg_idx_t idx, logic [LBW-1:0] data);
		row_t r;
		r = mk_pt('0, '0, '0, '0, 1'b0);
		r.kind = ROW_CFG;
		r.idx = idx;
		r.data = data;
		return r;
	endfunction

	function automatic box_t mk_box(logic signed [VW-1:0] lx, logic signed [VW-1:0] hx,
			logic signed [VW-1:0] ly, logic signed [VW-1:0] hy,
			logic signed [VW-1:0] lz, logic signed [VW-1:0] hz, bit mixed);
		box_t b;
		b.min_x = lx;
		b.max_x = hx;
		b.min_y = ly;
		b.max_y = hy;
		b.min_z = lz;
		b.max_z = hz;
		b.mixed_weights = mixed;
		return b;
	endfunction

	function automatic logic signed [CW-1:0] rand_weight(int sign_mode);
		logic [CW-2:0] mag;
		bit neg;
		if ($urandom_range(0, 99) < 8)
			return '0;
		case ($urandom_range(0, 4))
			0: mag = (CW-1)'($urandom_range(1, 1 << 18));
			1: mag = (CW-1)'($urandom | 1);
			2: mag = (CW-1)'(1);
			3: mag = '1;
			default: mag = (CW-1)'(65536 * $urandom_range(1, 16));
		endcase
		neg = (sign_mode == 1) || (sign_mode == 2 && $urandom_range(0, 1) == 1);
		if (!neg)
			return {1'b0, mag};
		if ($urandom_range(0, 19) == 0)
			return {1'b1, {(CW-1){1'b0}}};
		return -$signed({1'b0, mag});
	endfunction

	function automatic logic signed [CW-1:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return {1'b1, {(CW-1){1'b0}}};
			2: return {1'b0, {(CW-1){1'b1}}};
			3, 4, 5: return CW'($urandom_range(0, 1 << 21) - (1 << 20));
			default: return CW'($urandom);
		endcase
	endfunction

	task automatic check_field(string nm, logic signed [VW-1:0] e, logic signed [VW-1:0] a);
		if (e !== a) begin
			err_count++;
			$display("%0t: box %s mismatch, expected %0d, actual %0d", $time, nm, e, a);
		end
	endtask

	task automatic wait_idle();
		point_valid <= 1'b0;
		while (boxes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [LBW-1:0] data);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		reg_writes++;
		case (idx)
			CFG_RATIONAL: cf_rational = data[0];
			CFG_IGNORE:   cf_ignore = data[0];
			CFG_MASK:     cf_mask = data[2:0];
			CFG_LARGE:    cf_large = data;
		endcase
	endtask

	task automatic send_point(point_t p, bit typed, box_t want);
		bit done;
		box_t b;
		while ($urandom_range(0, 99) < send_pct) begin
			point_valid <= 1'b0;
			@(posedge clk);
		end
		point_valid <= 1'b1;
		point <= p;
		@(posedge clk);
		while (point_stall)
			@(posedge clk);
		points_sent++;
		fold_point(p, done, b);
		if (done)
			boxes_due.push_back(typed ? want : b);
	endtask

	always @(posedge clk) begin : box_monitor
		box_t want;
		if (arst_n && box_valid && !box_stall) begin
			if (boxes_due.size() == 0) begin
				err_count++;
				$display("%0t: unexpected box, expected none, actual %p", $time, box);
			end else begin
				want = boxes_due.pop_front();
				boxes_checked++;
				check_field("min_x", want.min_x, box.min_x);
				check_field("max_x", want.max_x, box.max_x);
				check_field("min_y", want.min_y, box.min_y);
				check_field("max_y", want.max_y, box.max_y);
				check_field("min_z", want.min_z, box.min_z);
				check_field("max_z", want.max_z, box.max_z);
				check_field("mixed_weights", VW'(want.mixed_weights), VW'(box.mixed_weights));
			end
		end
		box_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin : stimulus
		row_t plan[$];
		row_t r;
		point_t p;
		logic signed [CW-1:0] imin;
		logic signed [CW-1:0] imax;
		logic signed [VW-1:0] lb;
		int send_mode[4];
		int stall_mode[4];
		int phase_points;
		int len;
		int sign_mode;
		logic [LBW-1:0] lb_pick;
		imin = {1'b1, {(CW-1){1'b0}}};
		imax = {1'b0, {(CW-1){1'b1}}};
		lb = {1'b0, LB_RESET};
		send_mode = '{0, 74, 0, 18};
		stall_mode = '{0, 0, 74, 18};
		clear_tracks();

		r = mk_pt(0, imin, imax, 0, 1'b1);
		r.typed = 1'b1;
		r.want = mk_box(VW'(imin), VW'(imin), VW'(imax), VW'(imax), '0, '0, 1'b0);
		plan.push_back(r);
		plan.push_back(mk_pt(-1, 1, -1, 5, 1'b0));
		plan.push_back(mk_pt(7, -3, 2, imax, 1'b1));
		plan.push_back(mk_cfg(CFG_RATIONAL, 1));
		r = mk_pt(0, 5, -5, 0, 1'b1);
		r.typed = 1'b1;
		r.want = mk_box(POS_INF, POS_INF, NEG_INF, NEG_INF, POS_INF, NEG_INF, 1'b0);
		plan.push_back(r);
		plan.push_back(mk_pt(32'sh10000, imin, imax, 0, 1'b0));
		r = mk_pt(-32'sh10000, 32'sh10000, -7, 0, 1'b1);
		r.typed = 1'b1;
		r.want = mk_box(-lb, lb, -lb, lb, -lb, lb, 1'b1);
		plan.push_back(r);
		plan.push_back(mk_pt(1, imax, imin, 1, 1'b1));
		plan.push_back(mk_pt(-1, imin, imax, 0, 1'b1));
		plan.push_back(mk_pt(imin, imin, imax, -1, 1'b1));
		plan.push_back(mk_cfg(CFG_IGNORE, 1));
		plan.push_back(mk_pt(0, 3, -3, 0, 1'b0));
		plan.push_back(mk_pt(-2, 4, 6, -8, 1'b0));
		plan.push_back(mk_pt(2, 4, -6, 8, 1'b1));
		plan.push_back(mk_cfg(CFG_MASK, 0));
		r = mk_pt(5, imax, imin, 9, 1'b1);
		r.typed = 1'b1;
		r.want = '0;
		plan.push_back(r);
		plan.push_back(mk_cfg(CFG_MASK, 5));
		plan.push_back(mk_cfg(CFG_LARGE, '1));
		plan.push_back(mk_cfg(CFG_IGNORE, 0));
		plan.push_back(mk_pt(3, 100, -200, 300, 1'b0));
		plan.push_back(mk_pt(-3, -100, 200, 0, 1'b0));
		plan.push_back(mk_cfg(CFG_RATIONAL, 0));
		plan.push_back(mk_pt(9, 11, -22, 33, 1'b1));
		plan.push_back(mk_cfg(CFG_LARGE, 0));
		plan.push_back(mk_cfg(CFG_RATIONAL, 1));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG)
				write_reg(plan[i].idx, plan[i].data);
			else
				send_point(plan[i].pt, plan[i].typed, plan[i].want);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			send_pct = 0;
			stall_pct = 0;
			case ($urandom_range(0, 3))
				0: lb_pick = '0;
				1: lb_pick = '1;
				2: lb_pick = LB_RESET;
				default: lb_pick = LBW'({$urandom, $urandom});
			endcase
			if (ph == 0) begin
				write_reg(CFG_RATIONAL, 1);
				write_reg(CFG_IGNORE, 0);
				write_reg(CFG_MASK, 7);
				write_reg(CFG_LARGE, '1);
			end else if (ph == 1) begin
				write_reg(CFG_RATIONAL, 1);
				write_reg(CFG_IGNORE, 1);
				write_reg(CFG_MASK, LBW'($urandom_range(0, 7)));
				write_reg(CFG_LARGE, '0);
			end else begin
				write_reg(CFG_RATIONAL, LBW'($urandom_range(0, 9) < 8));
				write_reg(CFG_IGNORE, LBW'($urandom_range(0, 1)));
				write_reg(CFG_MASK, ($urandom_range(0, 1) == 1) ? 7 : LBW'($urandom_range(0, 7)));
				write_reg(CFG_LARGE, lb_pick);
			end
			send_pct = send_mode[ph % 4];
			stall_pct = stall_mode[ph % 4];
			phase_points = 0;
			while (phase_points < PHASE_POINTS) begin
				len = $urandom_range(1, 6);
				sign_mode = $urandom_range(0, 2);
				for (int i = 0; i < len; i++) begin
					p.weight = rand_weight(sign_mode);
					p.coord_x = rand_coord();
					p.coord_y = rand_coord();
					p.coord_z = rand_coord();
					p.last_point = (i == len - 1);
					send_point(p, 1'b0, '0);
					phase_points++;
				end
			end
		end

		point_valid <= 1'b0;
		while (boxes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("Ran %0d points through %0d register writes and %0d idle/stall phases,",
			points_sent, reg_writes, PHASES);
		$display("comparing %0d boxes field by field against the predicted bounds.",
			boxes_checked);
		if (err_count == 0 && boxes_due.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
